// ----- hdl/wpsp_pkg.sv -----
// shared widths, pipeline depths and helper functions for the world-to-screen projection
// used by every module of the block; no dependencies
package wpsp_pkg;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 60;
  localparam int unsigned COORD_W     = 20;
  localparam int unsigned REL_W       = 21;
  localparam int unsigned CAM_W       = 25;
  localparam int unsigned FOCAL_W     = 24;
  localparam int unsigned DIM_W       = 13;
  localparam int unsigned SCREEN_W    = 24;
  localparam int unsigned DEPTH_W     = 22;
  localparam int unsigned OFF_W       = 28;
  localparam int unsigned DIV_N       = 26;
  localparam int unsigned XF_LAT      = 3;
  localparam int unsigned PJ_LAT      = DIV_N + 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAM_POSITION  = 3'd0,
    REG_RIGHT_AXIS    = 3'd1,
    REG_UP_AXIS       = 3'd2,
    REG_FORWARD_AXIS  = 3'd3,
    REG_NEAR_LIMIT    = 3'd4,
    REG_FAR_LIMIT     = 3'd5,
    REG_FOCAL_FACTOR  = 3'd6,
    REG_VIEWPORT_SIZE = 3'd7
  } cfg_reg_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(4096)) r = DIM_W'(4096);
    return r;
  endfunction

  function automatic logic signed [SCREEN_W-1:0] sat_screen(input logic signed [28:0] v);
    logic signed [SCREEN_W-1:0] r;
    if (v > 29'sd8388607) r = 24'sh7fffff;
    else if (v < -29'sd8388608) r = 24'sh800000;
    else r = v[SCREEN_W-1:0];
    return r;
  endfunction

  function automatic logic signed [DEPTH_W-1:0] sat_depth(input logic signed [CAM_W-1:0] v);
    logic signed [DEPTH_W-1:0] r;
    if (v > 25'sd2097151) r = 22'sh1fffff;
    else if (v < -25'sd2097152) r = 22'sh200000;
    else r = v[DEPTH_W-1:0];
    return r;
  endfunction

endpackage

// ----- hdl/wpsp_if.sv -----
// valid/ready channel interfaces for world points in and screen results out
// depends on wpsp_pkg for field widths
interface wpsp_in_if;
  logic valid;
  logic ready;
  logic signed [wpsp_pkg::COORD_W-1:0] point_x;
  logic signed [wpsp_pkg::COORD_W-1:0] point_y;
  logic signed [wpsp_pkg::COORD_W-1:0] point_z;
  modport source(output valid, point_x, point_y, point_z, input ready);
  modport sink(input valid, point_x, point_y, point_z, output ready);
endinterface

interface wpsp_out_if;
  logic valid;
  logic ready;
  logic visible;
  logic signed [wpsp_pkg::SCREEN_W-1:0] screen_x;
  logic signed [wpsp_pkg::SCREEN_W-1:0] screen_y;
  logic signed [wpsp_pkg::DEPTH_W-1:0]  depth;
  modport source(output valid, visible, screen_x, screen_y, depth, input ready);
  modport sink(input valid, visible, screen_x, screen_y, depth, output ready);
endinterface

// ----- hdl/world_point_to_screen_projection.sv -----
// World point to screen projection, top level.
// Input channel in_ch carries one world point (point_x/y/z, signed Q12.8) per
// request; output channel out_ch carries visible, screen_x, screen_y (signed
// Q20.4, saturated) and depth (signed Q14.8, saturated), one result per point.
// Configuration is written through cfg_we/cfg_idx/cfg_data, one register per
// cycle. The user must write it only while no point is in flight; the block
// does not enforce this. An accepted point passes through the camera
// transform, scaling with rounding of the numerator, the bit-per-stage divider,
// a register that applies the sign to the offset, and the output register.
// Throughput is one point per cycle while out_ch does not stall.
// When out_ch stalls with a result waiting, the whole pipeline holds and
// in_ch.ready drops; nothing is dropped or repeated.
// Synchronous active-low reset empties the pipeline and loads the default
// camera: origin, identity axes, near 0.1, far max, focal 1.0, 640x480.
// Depends on wpsp_pkg, wpsp_if, wpsp_xform and wpsp_proj.
module world_point_to_screen_projection (
  input  logic                                  clk,
  input  logic                                  rst_n,
  wpsp_in_if.sink                               in_ch,
  wpsp_out_if.source                            out_ch,
  input  logic                                  cfg_we,
  input  logic [wpsp_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [wpsp_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int unsigned DW  = wpsp_pkg::CFG_DATA_W;
  localparam int unsigned LAT = wpsp_pkg::XF_LAT + wpsp_pkg::PJ_LAT;
  localparam int unsigned PL  = wpsp_pkg::PJ_LAT;

  logic [DW-1:0] cam_r, axr_r, axu_r, axf_r;
  logic [19:0]   near_r, far_r;
  logic [wpsp_pkg::FOCAL_W-1:0] focal_r;
  logic [25:0]   vp_r;

  logic en;
  logic [LAT-1:0] vld_r;
  logic signed [wpsp_pkg::CAM_W-1:0] cx, cy, cz;
  logic vis_nxt;
  logic vis_r [PL];
  logic signed [wpsp_pkg::DEPTH_W-1:0] dep_r [PL];
  logic [wpsp_pkg::DIM_W-1:0] wd, ht;
  logic signed [wpsp_pkg::OFF_W-1:0] offx, offy;
  logic signed [28:0] sx_sum, sy_sum;

  logic out_valid_r, vis_o_r;
  logic signed [wpsp_pkg::SCREEN_W-1:0] sx_r, sy_r;
  logic signed [wpsp_pkg::DEPTH_W-1:0]  dep_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r   <= '0;
      axr_r   <= DW'(262144);
      axu_r   <= DW'(64'd274877906944);
      axf_r   <= DW'(64'd288230376151711744);
      near_r  <= 20'd26;
      far_r   <= 20'd524287;
      focal_r <= 24'd65536;
      vp_r    <= 26'd3932800;
    end else if (cfg_we) begin
      unique case (wpsp_pkg::cfg_reg_t'(cfg_idx))
        wpsp_pkg::REG_CAM_POSITION:  cam_r   <= cfg_data;
        wpsp_pkg::REG_RIGHT_AXIS:    axr_r   <= cfg_data;
        wpsp_pkg::REG_UP_AXIS:       axu_r   <= cfg_data;
        wpsp_pkg::REG_FORWARD_AXIS:  axf_r   <= cfg_data;
        wpsp_pkg::REG_NEAR_LIMIT:    near_r  <= cfg_data[19:0];
        wpsp_pkg::REG_FAR_LIMIT:     far_r   <= cfg_data[19:0];
        wpsp_pkg::REG_FOCAL_FACTOR:  focal_r <= cfg_data[wpsp_pkg::FOCAL_W-1:0];
        wpsp_pkg::REG_VIEWPORT_SIZE: vp_r    <= cfg_data[25:0];
        default: ;
      endcase
    end
  end

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[LAT-2:0], in_ch.valid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  wpsp_xform u_xform (
    .clk  (clk),
    .en   (en),
    .px   (in_ch.point_x),
    .py   (in_ch.point_y),
    .pz   (in_ch.point_z),
    .cam  (cam_r),
    .ax_r (axr_r),
    .ax_u (axu_r),
    .ax_f (axf_r),
    .cx   (cx),
    .cy   (cy),
    .cz   (cz)
  );

  assign wd = wpsp_pkg::clamp_dim(vp_r[12:0]);
  assign ht = wpsp_pkg::clamp_dim(vp_r[25:13]);

  wpsp_proj u_proj_x (
    .clk   (clk),
    .en    (en),
    .c     (cx),
    .cz    (cz),
    .focal (focal_r),
    .hgt   (ht),
    .off   (offx)
  );

  wpsp_proj u_proj_y (
    .clk   (clk),
    .en    (en),
    .c     (cy),
    .cz    (cz),
    .focal (focal_r),
    .hgt   (ht),
    .off   (offy)
  );

  assign vis_nxt = (cz > wpsp_pkg::CAM_W'($signed(near_r))) &&
                   (cz < wpsp_pkg::CAM_W'($signed(far_r)));

  always_ff @(posedge clk) begin
    if (en) begin
      vis_r[0] <= vis_nxt;
      dep_r[0] <= wpsp_pkg::sat_depth(cz);
      for (int i = 1; i < PL; i++) begin
        vis_r[i] <= vis_r[i-1];
        dep_r[i] <= dep_r[i-1];
      end
    end
  end

  assign sx_sum = $signed({13'b0, wd, 3'b0}) + 29'(offx);
  assign sy_sum = $signed({13'b0, ht, 3'b0}) - 29'(offy);

  always_ff @(posedge clk) begin
    if (en) begin
      vis_o_r <= vis_r[PL-1];
      dep_o_r <= dep_r[PL-1];
      sx_r    <= vis_r[PL-1] ? wpsp_pkg::sat_screen(sx_sum) : '0;
      sy_r    <= vis_r[PL-1] ? wpsp_pkg::sat_screen(sy_sum) : '0;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.visible  = vis_o_r;
  assign out_ch.screen_x = sx_r;
  assign out_ch.screen_y = sy_r;
  assign out_ch.depth    = dep_o_r;

endmodule

// ----- hdl/wpsp_xform.sv -----
// world to camera space: camera offset, nine products, rounded dot products
// three register stages; depends on wpsp_pkg
module wpsp_xform (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [wpsp_pkg::COORD_W-1:0] px,
  input  logic signed [wpsp_pkg::COORD_W-1:0] py,
  input  logic signed [wpsp_pkg::COORD_W-1:0] pz,
  input  logic [wpsp_pkg::CFG_DATA_W-1:0]     cam,
  input  logic [wpsp_pkg::CFG_DATA_W-1:0]     ax_r,
  input  logic [wpsp_pkg::CFG_DATA_W-1:0]     ax_u,
  input  logic [wpsp_pkg::CFG_DATA_W-1:0]     ax_f,
  output logic signed [wpsp_pkg::CAM_W-1:0]   cx,
  output logic signed [wpsp_pkg::CAM_W-1:0]   cy,
  output logic signed [wpsp_pkg::CAM_W-1:0]   cz
);

  localparam int unsigned CW = wpsp_pkg::COORD_W;
  localparam int unsigned RW = wpsp_pkg::REL_W;
  localparam int unsigned PW = RW + CW;
  localparam int unsigned SW = PW + 2;

  logic signed [RW-1:0] rel_r [3];
  logic signed [RW-1:0] rel_nxt [3];
  logic signed [PW-1:0] prod_r [3][3];
  logic signed [wpsp_pkg::CAM_W-1:0] c_r [3];
  logic signed [wpsp_pkg::CAM_W-1:0] c_nxt [3];
  logic [wpsp_pkg::CFG_DATA_W-1:0] axes [3];

  assign axes[0] = ax_r;
  assign axes[1] = ax_u;
  assign axes[2] = ax_f;

  always_comb begin
    rel_nxt[0] = RW'(px) - RW'($signed(cam[CW-1:0]));
    rel_nxt[1] = RW'(py) - RW'($signed(cam[2*CW-1:CW]));
    rel_nxt[2] = RW'(pz) - RW'($signed(cam[3*CW-1:2*CW]));
  end

  always_comb begin
    logic signed [SW-1:0] acc;
    for (int a = 0; a < 3; a++) begin
      acc = SW'(prod_r[a][0]) + SW'(prod_r[a][1]) + SW'(prod_r[a][2]) + SW'(1 << 17);
      c_nxt[a] = acc[SW-1:18];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rel_r[i] <= rel_nxt[i];
        c_r[i]   <= c_nxt[i];
        for (int a = 0; a < 3; a++) begin
          prod_r[a][i] <= PW'(rel_r[i]) * PW'($signed(axes[a][CW*i +: CW]));
        end
      end
    end
  end

  assign cx = c_r[0];
  assign cy = c_r[1];
  assign cz = c_r[2];

endmodule

// ----- hdl/wpsp_proj.sv -----
// one screen offset: coordinate times focal factor times height, then a
// rounded divide by depth in a one-bit-per-stage pipeline; depends on wpsp_pkg
module wpsp_proj (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [wpsp_pkg::CAM_W-1:0]   c,
  input  logic signed [wpsp_pkg::CAM_W-1:0]   cz,
  input  logic [wpsp_pkg::FOCAL_W-1:0]        focal,
  input  logic [wpsp_pkg::DIM_W-1:0]          hgt,
  output logic signed [wpsp_pkg::OFF_W-1:0]   off
);

  localparam int unsigned MW  = wpsp_pkg::CAM_W;
  localparam int unsigned P1W = MW + wpsp_pkg::FOCAL_W;
  localparam int unsigned P2W = P1W + wpsp_pkg::DIM_W;
  localparam int unsigned ND  = wpsp_pkg::DIV_N;
  localparam int unsigned NW  = P2W + 1 - 13;

  logic [MW-1:0]  cmag, dmag;
  logic [P1W-1:0] p1_r;
  logic [P2W-1:0] p2_r;
  logic [MW-1:0]  dm1_r, dm2_r, dm3_r;
  logic           ng1_r, ng2_r, ng3_r;
  logic           dz1_r, dz2_r, dz3_r;
  logic [P2W:0]   nsum;
  logic [NW-1:0]  n_r;
  logic           ovf_nxt, ovf_r;

  logic [MW-1:0] rem_r [ND];
  logic [ND-1:0] nlo_r [ND];
  logic [ND-1:0] q_r   [ND];
  logic [MW-1:0] dmd_r [ND];
  logic          ngd_r [ND];
  logic          dzd_r [ND];
  logic          ovd_r [ND];

  logic [ND:0]   mag;
  logic signed [wpsp_pkg::OFF_W-1:0] off_r;

  assign cmag = c[MW-1]  ? MW'(-c)  : MW'(c);
  assign dmag = cz[MW-1] ? MW'(-cz) : MW'(cz);

  assign nsum    = (P2W+1)'(p2_r) + (P2W+1)'({dm2_r, 12'b0});
  assign ovf_nxt = dz2_r ? (p2_r != '0) : ({1'b0, nsum[P2W:13]} >= {dm2_r, ND'(0)});

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= P1W'(cmag) * P1W'(focal);
      dm1_r <= dmag;
      ng1_r <= c[MW-1] ^ cz[MW-1];
      dz1_r <= (cz == '0);
      p2_r  <= P2W'(p1_r) * P2W'(hgt);
      dm2_r <= dm1_r;
      ng2_r <= ng1_r;
      dz2_r <= dz1_r;
      n_r   <= nsum[P2W:13];
      ovf_r <= ovf_nxt;
      dm3_r <= dm2_r;
      ng3_r <= ng2_r;
      dz3_r <= dz2_r;
    end
  end

  for (genvar k = 0; k < ND; k++) begin : g_div
    logic [MW-1:0] rin, dsr;
    logic [ND-1:0] lin, qin;
    logic          ngi, dzi, ovi;
    logic [MW:0]   tmp;
    logic          ge;
    if (k == 0) begin : g_first
      assign rin = MW'(n_r[NW-1:ND]);
      assign lin = n_r[ND-1:0];
      assign qin = '0;
      assign dsr = dm3_r;
      assign ngi = ng3_r;
      assign dzi = dz3_r;
      assign ovi = ovf_r;
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign lin = nlo_r[k-1];
      assign qin = q_r[k-1];
      assign dsr = dmd_r[k-1];
      assign ngi = ngd_r[k-1];
      assign dzi = dzd_r[k-1];
      assign ovi = ovd_r[k-1];
    end
    assign tmp = {rin, lin[ND-1]};
    assign ge  = tmp >= {1'b0, dsr};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? MW'(tmp - {1'b0, dsr}) : tmp[MW-1:0];
        nlo_r[k] <= {lin[ND-2:0], 1'b0};
        q_r[k]   <= {qin[ND-2:0], ge};
        dmd_r[k] <= dsr;
        ngd_r[k] <= ngi;
        dzd_r[k] <= dzi;
        ovd_r[k] <= ovi;
      end
    end
  end

  always_comb begin
    if (ovd_r[ND-1]) mag = (ND+1)'(1) << ND;
    else if (dzd_r[ND-1]) mag = '0;
    else mag = {1'b0, q_r[ND-1]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off_r <= ngd_r[ND-1] ? -wpsp_pkg::OFF_W'(mag) : wpsp_pkg::OFF_W'(mag);
    end
  end

  assign off = off_r;

endmodule
